### rtl/cdc_pkg.sv
// ---------------------------------------------------------------------------
// cdc_pkg
// Shared types and codes for the coherence directory controller.
// ---------------------------------------------------------------------------
package cdc_pkg;

    localparam int LINE_W  = 48;
    localparam int PRES_W  = 16;
    localparam int TOK_W   = 5;
    localparam int SRC_W   = 4;
    localparam int SET_W   = 20;

    // request type codes
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_EVICT = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE        = 3'd0;
    localparam logic [2:0] CFG_NUM_CACHES  = 3'd1;
    localparam logic [2:0] CFG_OFFSET_BITS = 3'd2;
    localparam logic [2:0] CFG_SET_BITS    = 3'd3;

    typedef enum logic [1:0] {
        K_READ,
        K_WRITE,
        K_EVICT,
        K_IGNORE
    } kind_t;

    // classified word handed from front to back
    typedef struct packed {
        kind_t               kind;
        logic [SRC_W-1:0]    src;
        logic [LINE_W-1:0]   line;
        logic [TOK_W-1:0]    tok;
    } item_t;

    // one directory entry as stored in RAM
    typedef struct packed {
        logic                valid;
        logic [LINE_W-1:0]   line;
        logic [PRES_W-1:0]   pres;
        logic                dirty;
        logic [TOK_W-1:0]    tokens;
    } entry_t;

endpackage

### rtl/coherence_directory_controller.sv
// A request or eviction is popped, the directory RAM is scanned for its line one
// entry per cycle, then the entry is updated and the result registered; an ignored
// word skips the scan. The back end takes no new word until done with the last; a
// two-word queue takes words meanwhile. Reset: config returns to defaults, then a
// clearing pass invalidates every entry; no word is taken until it ends.
// ---------------------------------------------------------------------------
// coherence_directory_controller
// Full-map / token coherence directory: config registers, front end and
// scanning back end.
// ---------------------------------------------------------------------------
module coherence_directory_controller
    import cdc_pkg::*;
#(
    parameter int DIR_ENTRIES = 64,
    parameter int MAX_CACHES  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [SRC_W-1:0]   source_id,
    input  logic [LINE_W-1:0]  address,
    input  logic [SET_W-1:0]   set_id,
    input  logic [LINE_W-1:0]  tag,
    input  logic [TOK_W-1:0]   token_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PRES_W-1:0]  owner_mask,
    output logic [TOK_W-1:0]   token_grant,
    output logic               memory_fetch,
    output logic               table_full,
    output logic               not_found
);

    localparam logic [5:0] MAXC = (MAX_CACHES > 31) ? 6'd31 : 6'(MAX_CACHES);

    logic               mode_reg;
    logic [4:0]         ncache_reg;
    logic [3:0]         offset_reg;
    logic [4:0]         setb_reg;
    logic [4:0]         n_caches;
    logic [PRES_W-1:0]  nmask;
    logic               clearing;
    logic               q_valid;
    logic               q_pop;
    item_t              q_item;

    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            ncache_reg <= 5'd4;
            offset_reg <= 4'd6;
            setb_reg   <= 5'd6;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:        mode_reg   <= cfg_data[0];
                CFG_NUM_CACHES:  ncache_reg <= cfg_data;
                CFG_OFFSET_BITS: offset_reg <= cfg_data[3:0];
                CFG_SET_BITS:    setb_reg   <= cfg_data;
                default:         mode_reg   <= mode_reg;
            endcase
        end
    end

    // effective cache count and its presence mask
    always_comb
    begin
        if (ncache_reg == 5'd0)
        begin
            n_caches = 5'd1;
        end
        else if ({1'b0, ncache_reg} > MAXC)
        begin
            n_caches = MAXC[4:0];
        end
        else
        begin
            n_caches = ncache_reg;
        end
        for (int i = 0; i < PRES_W; i++)
        begin
            nmask[i] = (5'(i) < n_caches);
        end
    end

    cdc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .hold        (clearing),
        .token_mode  (mode_reg),
        .n_caches    (n_caches),
        .offset_bits (offset_reg),
        .set_bits    (setb_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .source_id   (source_id),
        .address     (address),
        .set_id      (set_id),
        .tag         (tag),
        .token_count (token_count),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    cdc_back #(
        .DIR_ENTRIES(DIR_ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_mode   (mode_reg),
        .n_caches     (n_caches),
        .nmask        (nmask),
        .clearing     (clearing),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .owner_mask   (owner_mask),
        .token_grant  (token_grant),
        .memory_fetch (memory_fetch),
        .table_full   (table_full),
        .not_found    (not_found)
    );

endmodule

### rtl/cdc_ram.sv
// ---------------------------------------------------------------------------
// cdc_ram
// Generic simple dual-port RAM, one write port, registered read.
// ---------------------------------------------------------------------------
module cdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/cdc_front.sv
// ---------------------------------------------------------------------------
// cdc_front
// Accepts request words, forms the line id, classifies them and queues
// them for the back end in a two-word queue.
// ---------------------------------------------------------------------------
module cdc_front
    import cdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               hold,
    input  logic               token_mode,
    input  logic [4:0]         n_caches,
    input  logic [3:0]         offset_bits,
    input  logic [4:0]         set_bits,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [SRC_W-1:0]   source_id,
    input  logic [LINE_W-1:0]  address,
    input  logic [SET_W-1:0]   set_id,
    input  logic [LINE_W-1:0]  tag,
    input  logic [TOK_W-1:0]   token_count,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_pop
);

    item_t       slot_reg [2];
    item_t       cls;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;

    // classify the incoming word
    always_comb
    begin
        cls.src = source_id;
        cls.tok = token_count;
        if (req_type == REQ_EVICT)
        begin
            cls.line = LINE_W'({{(LINE_W-SET_W){1'b0}}, set_id} | (tag << set_bits));
        end
        else
        begin
            cls.line = LINE_W'(address >> offset_bits);
        end
        case (req_type)
            REQ_READ:  cls.kind = K_READ;
            REQ_WRITE: cls.kind = K_WRITE;
            REQ_EVICT: cls.kind = K_EVICT;
            default:   cls.kind = K_IGNORE;
        endcase
        if (!token_mode && ({1'b0, source_id} >= n_caches))
        begin
            cls.kind = K_IGNORE;
        end
    end

    assign in_stall = hold || (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = 2'(cnt_reg + {1'b0, push} - {1'b0, q_pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

### rtl/cdc_back.sv
// ---------------------------------------------------------------------------
// cdc_back
// Scans the directory RAM for the line, updates at most one entry and
// registers the result word. Clears the RAM after reset.
// ---------------------------------------------------------------------------
module cdc_back
    import cdc_pkg::*;
#(
    parameter int DIR_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               token_mode,
    input  logic [4:0]         n_caches,
    input  logic [PRES_W-1:0]  nmask,
    output logic               clearing,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PRES_W-1:0]  owner_mask,
    output logic [TOK_W-1:0]   token_grant,
    output logic               memory_fetch,
    output logic               table_full,
    output logic               not_found
);

    localparam int AW = $clog2(DIR_ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(DIR_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_APPLY
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [AW-1:0]      chk_idx_reg, chk_idx_next;
    logic               hit_reg, hit_next;
    logic [AW-1:0]      hit_idx_reg, hit_idx_next;
    entry_t             hit_word_reg, hit_word_next;
    logic               free_reg, free_next;
    logic [AW-1:0]      free_idx_reg, free_idx_next;
    item_t              item_reg, item_next;
    logic               out_valid_reg, out_valid_next;
    logic [PRES_W-1:0]  owner_reg, owner_next;
    logic [TOK_W-1:0]   grant_reg, grant_next;
    logic               mem_reg, mem_next;
    logic               full_reg, full_next;
    logic               nf_reg, nf_next;

    logic               we;
    logic [AW-1:0]      waddr;
    entry_t             wdata;
    logic [AW-1:0]      raddr;
    entry_t             rdata;

    // entry update terms
    entry_t             base, upd;
    logic [PRES_W-1:0]  sbit, pres;
    logic [TOK_W:0]     tsum;
    logic               do_write;
    logic [PRES_W-1:0]  r_owner;
    logic [TOK_W-1:0]   r_grant;
    logic               r_mem, r_full, r_nf;
    logic               out_free;

    cdc_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(DIR_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // result and new entry for the item in hand
    always_comb
    begin
        sbit     = PRES_W'(1) << item_reg.src;
        base     = hit_word_reg;
        if (!hit_reg)
        begin
            base.valid  = 1'b1;
            base.line   = item_reg.line;
            base.pres   = '0;
            base.dirty  = 1'b0;
            base.tokens = n_caches;
        end
        pres     = base.pres & nmask;
        upd      = base;
        tsum     = {1'b0, base.tokens} + {1'b0, item_reg.tok};
        do_write = 1'b0;
        r_owner  = '0;
        r_grant  = '0;
        r_mem    = 1'b0;
        r_full   = 1'b0;
        r_nf     = 1'b0;
        case (item_reg.kind)
            K_EVICT:
            begin
                if (!hit_reg)
                begin
                    r_nf = 1'b1;
                end
                else if (token_mode)
                begin
                    do_write = 1'b1;
                    if (tsum >= {1'b0, n_caches})
                    begin
                        upd.tokens = n_caches;
                        upd.valid  = 1'b0;
                    end
                    else
                    begin
                        upd.tokens = tsum[TOK_W-1:0];
                    end
                end
                else
                begin
                    do_write  = 1'b1;
                    upd.pres  = base.pres & ~sbit;
                    if (base.dirty || ((upd.pres & nmask) == '0))
                    begin
                        upd.valid = 1'b0;
                    end
                end
            end
            K_READ, K_WRITE:
            begin
                if (!hit_reg && !free_reg)
                begin
                    r_full = 1'b1;
                end
                else
                begin
                    do_write = 1'b1;
                    r_mem    = !hit_reg;
                    if (token_mode)
                    begin
                        if (item_reg.kind == K_READ)
                        begin
                            if (base.tokens != '0)
                            begin
                                upd.tokens = base.tokens - TOK_W'(1);
                                r_grant    = TOK_W'(1);
                            end
                        end
                        else
                        begin
                            r_grant    = base.tokens;
                            upd.tokens = '0;
                        end
                    end
                    else if (item_reg.kind == K_READ)
                    begin
                        r_owner   = pres;
                        upd.dirty = 1'b0;
                        upd.pres  = pres | sbit;
                    end
                    else
                    begin
                        r_owner   = base.dirty ? pres : (pres & ~sbit);
                        upd.dirty = 1'b1;
                        upd.pres  = sbit;
                    end
                end
            end
            default:
            begin
                do_write = 1'b0;
            end
        endcase
    end

    // control sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_word_next  = hit_word_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg && out_stall;
        owner_next     = owner_reg;
        grant_next     = grant_reg;
        mem_next       = mem_reg;
        full_next      = full_reg;
        nf_next        = nf_reg;
        q_pop          = 1'b0;
        we             = 1'b0;
        waddr          = idx_reg;
        wdata          = '0;
        raddr          = idx_reg;

        // compare the word read last cycle
        if (chk_vld_reg)
        begin
            if (!hit_reg && rdata.valid && (rdata.line == item_reg.line))
            begin
                hit_next      = 1'b1;
                hit_idx_next  = chk_idx_reg;
                hit_word_next = rdata;
            end
            if (!free_reg && !rdata.valid)
            begin
                free_next     = 1'b1;
                free_idx_next = chk_idx_reg;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                if (idx_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                    idx_next  = '0;
                    state_next = (q_item.kind == K_IGNORE) ? S_APPLY : S_SCAN;
                end
            end
            S_SCAN:
            begin
                chk_vld_next = 1'b1;
                chk_idx_next = idx_reg;
                if (idx_reg == LAST)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    we             = do_write;
                    waddr          = hit_reg ? hit_idx_reg : free_idx_reg;
                    wdata          = upd;
                    out_valid_next = 1'b1;
                    owner_next     = r_owner;
                    grant_next     = r_grant;
                    mem_next       = r_mem;
                    full_next      = r_full;
                    nf_next        = r_nf;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_vld_reg   <= chk_vld_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_word_reg <= hit_word_next;
        free_idx_reg <= free_idx_next;
        item_reg     <= item_next;
        owner_reg    <= owner_next;
        grant_reg    <= grant_next;
        mem_reg      <= mem_next;
        full_reg     <= full_next;
        nf_reg       <= nf_next;
    end

    assign clearing     = (state_reg == S_CLEAR);
    assign out_valid    = out_valid_reg;
    assign owner_mask   = owner_reg;
    assign token_grant  = grant_reg;
    assign memory_fetch = mem_reg;
    assign table_full   = full_reg;
    assign not_found    = nf_reg;

endmodule
